[rtl/core/hill_cipher_2x2_mod26_unit_macros.svh]
// Assertion macros shared by the Hill cipher core.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef HILL_CIPHER_2X2_MOD26_UNIT_MACROS_SVH
`define HILL_CIPHER_2X2_MOD26_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hc_pkg.sv]
// Shared types, constants and mod-26 helper functions for the Hill cipher core.
// No dependencies; every module in rtl/core imports this package.
package hc_pkg;

    localparam logic [4:0] ALPHA      = 5'd26;
    localparam logic [4:0] PAD_LETTER = 5'd23;

    localparam logic [7:0] CHAR_UP_A = 8'h41;
    localparam logic [7:0] CHAR_UP_Z = 8'h5A;
    localparam logic [7:0] CHAR_LO_A = 8'h61;
    localparam logic [7:0] CHAR_LO_Z = 8'h7A;

    localparam int KEY_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] IDX_KEY_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_KEY_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_KEY_C = 2'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_KEY_D = 2'd3;

    localparam logic [KEY_W-1:0] RST_KEY_A = 5'd9;
    localparam logic [KEY_W-1:0] RST_KEY_B = 5'd4;
    localparam logic [KEY_W-1:0] RST_KEY_C = 5'd5;
    localparam logic [KEY_W-1:0] RST_KEY_D = 5'd7;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    // Busy count loaded after reset or a register write to cover the key derivation pipeline.
    localparam logic [2:0] PREP_LOAD = 3'd4;

    localparam int PROD_W = 10;
    localparam int SUM_W  = 11;

    // 2521 / 2^16 is close enough to 1/26 that the quotient is exact below 1664.
    localparam logic [21:0] RECIP_26 = 22'd2521;
    localparam logic [10:0] DET_BIAS = 11'd676;

    typedef struct packed {
        logic [4:0] m00;
        logic [4:0] m01;
        logic [4:0] m10;
        logic [4:0] m11;
    } mat_t;

    typedef struct packed {
        logic busy;
        logic bad;
        mat_t enc;
        mat_t dec;
    } keys_t;

    typedef struct packed {
        logic       bad;
        logic       eot;
        logic       dec;
        logic [4:0] x;
        logic [4:0] y;
    } job_t;

    typedef struct packed {
        logic [4:0] letter;
        logic       key_bad;
        logic       pair_last;
        logic       text_last;
    } word_t;

    function automatic logic [4:0] red26(input logic [4:0] v);
        return (v >= ALPHA) ? 5'(v - ALPHA) : v;
    endfunction

    function automatic logic [4:0] neg26(input logic [4:0] v);
        return (v == 5'd0) ? 5'd0 : 5'(ALPHA - v);
    endfunction

    function automatic logic [4:0] mod26(input logic [SUM_W-1:0] v);
        logic [21:0]      prod;
        logic [5:0]       q;
        logic [SUM_W-1:0] r;
        prod = {11'd0, v} * RECIP_26;
        q    = prod[21:16];
        r    = v - ({5'd0, q} * SUM_W'(ALPHA));
        return r[4:0];
    endfunction

    // Inverse mod 26; zero marks a value with no inverse.
    function automatic logic [4:0] inv26(input logic [4:0] v);
        logic [4:0] r;
        unique case (v)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/hc_keyprep.sv]
// Key registers and the pipeline that derives the encrypt and decrypt matrices.
// Depends on hc_pkg.
module hc_keyprep (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [hc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hc_pkg::KEY_W-1:0]         cfg_data,
    output hc_pkg::keys_t                    keys
);
    import hc_pkg::*;

    logic [KEY_W-1:0]  key_a_reg, key_b_reg, key_c_reg, key_d_reg;
    logic [2:0]        busy_cnt_reg;
    logic [4:0]        ra_reg, rb_reg, rc_reg, rd_reg;
    logic [PROD_W-1:0] ad_reg, bc_reg;
    logic [4:0]        det_reg;
    logic              bad_reg;
    logic [PROD_W-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    mat_t              dec_reg;
    logic [4:0]        inv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg    <= RST_KEY_A;
            key_b_reg    <= RST_KEY_B;
            key_c_reg    <= RST_KEY_C;
            key_d_reg    <= RST_KEY_D;
            busy_cnt_reg <= PREP_LOAD;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                IDX_KEY_A: key_a_reg <= cfg_data;
                IDX_KEY_B: key_b_reg <= cfg_data;
                IDX_KEY_C: key_c_reg <= cfg_data;
                IDX_KEY_D: key_d_reg <= cfg_data;
            endcase
            busy_cnt_reg <= PREP_LOAD;
        end
        else if (busy_cnt_reg != 3'd0)
        begin
            busy_cnt_reg <= busy_cnt_reg - 3'd1;
        end
    end

    assign inv = inv26(det_reg);

    // The derivation runs every cycle; the busy count covers its depth.
    always_ff @(posedge clk)
    begin
        ra_reg  <= red26(key_a_reg);
        rb_reg  <= red26(key_b_reg);
        rc_reg  <= red26(key_c_reg);
        rd_reg  <= red26(key_d_reg);
        ad_reg  <= {5'd0, red26(key_a_reg)} * {5'd0, red26(key_d_reg)};
        bc_reg  <= {5'd0, red26(key_b_reg)} * {5'd0, red26(key_c_reg)};
        det_reg <= mod26(SUM_W'(ad_reg) + DET_BIAS - SUM_W'(bc_reg));
        bad_reg <= (inv == 5'd0);
        p00_reg <= {5'd0, rd_reg} * {5'd0, inv};
        p01_reg <= {5'd0, neg26(rb_reg)} * {5'd0, inv};
        p10_reg <= {5'd0, neg26(rc_reg)} * {5'd0, inv};
        p11_reg <= {5'd0, ra_reg} * {5'd0, inv};
        dec_reg.m00 <= mod26(SUM_W'(p00_reg));
        dec_reg.m01 <= mod26(SUM_W'(p01_reg));
        dec_reg.m10 <= mod26(SUM_W'(p10_reg));
        dec_reg.m11 <= mod26(SUM_W'(p11_reg));
    end

    always_comb
    begin
        keys.busy    = (busy_cnt_reg != 3'd0);
        keys.bad     = bad_reg;
        keys.enc.m00 = ra_reg;
        keys.enc.m01 = rb_reg;
        keys.enc.m10 = rc_reg;
        keys.enc.m11 = rd_reg;
        keys.dec     = dec_reg;
    end

endmodule

[rtl/core/hc_front.sv]
// Input side: accepts text bytes, folds letters, pairs them and issues jobs.
// Depends on hc_pkg; feeds hc_queue.
module hc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    char_in,
    input  logic          end_of_text,
    input  logic          mode,
    input  hc_pkg::keys_t keys,
    input  logic          q_full,
    output logic          push,
    output hc_pkg::job_t  job
);
    import hc_pkg::*;

    logic       have_held_reg, have_held_next;
    logic [4:0] held_reg, held_next;
    logic       is_up, is_lo, is_letter, accept;
    logic [7:0] diff_up, diff_lo;
    logic [4:0] letter;

    assign in_stall = q_full || keys.busy;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        is_up     = (char_in >= CHAR_UP_A) && (char_in <= CHAR_UP_Z);
        is_lo     = (char_in >= CHAR_LO_A) && (char_in <= CHAR_LO_Z);
        is_letter = is_up || is_lo;
        diff_up   = char_in - CHAR_UP_A;
        diff_lo   = char_in - CHAR_LO_A;
        letter    = is_up ? diff_up[4:0] : diff_lo[4:0];

        push           = 1'b0;
        job.bad        = 1'b0;
        job.eot        = end_of_text;
        job.dec        = mode;
        job.x          = held_reg;
        job.y          = PAD_LETTER;
        have_held_next = have_held_reg;
        held_next      = held_reg;

        if (accept)
        begin
            priority if (keys.bad)
            begin
                // A singular key drops any pending letter and flags each letter.
                have_held_next = 1'b0;
                held_next      = 5'd0;
                push           = is_letter;
                job.bad        = 1'b1;
            end
            else if (is_letter && !have_held_reg)
            begin
                held_next      = letter;
                have_held_next = 1'b1;
                if (end_of_text)
                begin
                    push           = 1'b1;
                    job.x          = letter;
                    have_held_next = 1'b0;
                    held_next      = 5'd0;
                end
            end
            else if (is_letter)
            begin
                push           = 1'b1;
                job.y          = letter;
                have_held_next = 1'b0;
                held_next      = 5'd0;
            end
            else if (end_of_text && have_held_reg)
            begin
                push           = 1'b1;
                have_held_next = 1'b0;
                held_next      = 5'd0;
            end
            else
            begin
                // Any other byte is skipped and the pending letter stays.
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_held_reg <= 1'b0;
            held_reg      <= 5'd0;
        end
        else
        begin
            have_held_reg <= have_held_next;
            held_reg      <= held_next;
        end
    end

endmodule

[rtl/core/hc_queue.sv]
// Short job queue between the front and back parts of the Hill cipher core.
// Depends on hc_pkg and the assertion macro header.
`include "hill_cipher_2x2_mod26_unit_macros.svh"

module hc_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  hc_pkg::job_t job_in,
    input  logic         pop,
    output hc_pkg::job_t head,
    output logic         full,
    output logic         empty
);
    import hc_pkg::*;

    job_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0] cnt_reg;

    assign full  = (cnt_reg == Q_CW'(Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + Q_CW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - Q_CW'(1);
            end
        end
    end

    `HC_ASSERT_IMP(a_no_overflow, push, !full, "job pushed into a full queue")
    `HC_ASSERT_IMP(a_no_underflow, pop, !empty, "job popped from an empty queue")
    `HC_ASSERT_NXT(a_push_fills, push && !pop, !empty, "queue empty after a push")

endmodule

[rtl/core/hc_back.sv]
// Back part: applies the selected key matrix to each pair, or flags a bad-key job, and emits result words.
// Depends on hc_pkg and the assertion macro header; fed by hc_queue.
`include "hill_cipher_2x2_mod26_unit_macros.svh"

module hc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  hc_pkg::keys_t keys,
    input  hc_pkg::job_t  head,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [4:0]    letter_out,
    output logic          key_bad,
    output logic          pair_last,
    output logic          text_last
);
    import hc_pkg::*;

    logic             b1_valid_reg;
    job_t             b1_job_reg;
    mat_t             b1_mat_reg;
    logic             b2_valid_reg;
    logic             b2_bad_reg, b2_eot_reg;
    logic [SUM_W-1:0] s0_reg, s1_reg;
    logic [1:0]       ocnt_reg, ocnt_next;
    word_t            w0_reg, w0_next, w1_reg, w1_next;

    logic              out_take, out_load, b2_adv, b1_adv;
    logic [PROD_W-1:0] p00, p01, p10, p11;

    // Word stage holds one pair; it reloads as its last word leaves.
    assign out_take = (ocnt_reg != 2'd0) && !out_stall;
    assign out_load = (ocnt_reg == 2'd0) || ((ocnt_reg == 2'd1) && out_take);
    assign b2_adv   = !b2_valid_reg || out_load;
    assign b1_adv   = !b1_valid_reg || b2_adv;
    assign pop      = b1_adv && !empty;

    always_comb
    begin
        p00 = {5'd0, b1_mat_reg.m00} * {5'd0, b1_job_reg.x};
        p01 = {5'd0, b1_mat_reg.m01} * {5'd0, b1_job_reg.y};
        p10 = {5'd0, b1_mat_reg.m10} * {5'd0, b1_job_reg.x};
        p11 = {5'd0, b1_mat_reg.m11} * {5'd0, b1_job_reg.y};
    end

    always_comb
    begin
        ocnt_next = ocnt_reg;
        w0_next   = w0_reg;
        w1_next   = w1_reg;
        priority if (out_load && b2_valid_reg)
        begin
            if (b2_bad_reg)
            begin
                w0_next   = '{letter: 5'd0, key_bad: 1'b1, pair_last: 1'b0,
                              text_last: b2_eot_reg};
                ocnt_next = 2'd1;
            end
            else
            begin
                w0_next   = '{letter: mod26(s0_reg), key_bad: 1'b0, pair_last: 1'b0,
                              text_last: 1'b0};
                w1_next   = '{letter: mod26(s1_reg), key_bad: 1'b0, pair_last: 1'b1,
                              text_last: b2_eot_reg};
                ocnt_next = 2'd2;
            end
        end
        else if (out_take)
        begin
            w0_next   = w1_reg;
            ocnt_next = ocnt_reg - 2'd1;
        end
        else
        begin
            // The word stage holds what it has.
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            ocnt_reg     <= 2'd0;
        end
        else
        begin
            if (b1_adv)
            begin
                b1_valid_reg <= !empty;
            end
            if (b2_adv)
            begin
                b2_valid_reg <= b1_valid_reg;
            end
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_job_reg <= head;
            b1_mat_reg <= head.dec ? keys.dec : keys.enc;
        end
        if (b2_adv)
        begin
            b2_bad_reg <= b1_job_reg.bad;
            b2_eot_reg <= b1_job_reg.eot;
            s0_reg     <= {1'b0, p00} + {1'b0, p01};
            s1_reg     <= {1'b0, p10} + {1'b0, p11};
        end
        w0_reg <= w0_next;
        w1_reg <= w1_next;
    end

    assign out_valid  = (ocnt_reg != 2'd0);
    assign letter_out = w0_reg.letter;
    assign key_bad    = w0_reg.key_bad;
    assign pair_last  = w0_reg.pair_last;
    assign text_last  = w0_reg.text_last;

    `HC_ASSERT_IMP(a_ocnt_range, 1'b1, ocnt_reg <= 2'd2, "word stage holds more than a pair")
    `HC_ASSERT_IMP(a_second_word, ocnt_reg == 2'd2, w1_reg.pair_last,
                   "waiting second word lacks pair_last")
    `HC_ASSERT_IMP(a_pair_good_key, out_valid && pair_last, !key_bad,
                   "pair word flagged with a bad key")

endmodule

[rtl/core/hill_cipher_2x2_mod26_unit.sv]
// A job passes the queue, the b1 and b2 stages and the word stage; a pair's second word follows.
// Throughput: one byte per cycle while in_stall is low; each letter pair yields two words.
// Rate is set by the one-word-per-cycle output stage while out_stall is low; a 4-deep job
// queue absorbs padding bursts. After reset and after every key register write, input is
// stalled while the key derivation pipeline settles.
module hill_cipher_2x2_mod26_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [hc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hc_pkg::KEY_W-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    char_in,
    input  logic                          end_of_text,
    input  logic                          mode,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [4:0]                    letter_out,
    output logic                          key_bad,
    output logic                          pair_last,
    output logic                          text_last
);
    import hc_pkg::*;

    keys_t keys;
    job_t  job, head;
    logic  push, pop, q_full, q_empty;

    hc_keyprep u_keyprep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (keys)
    );

    hc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_in     (char_in),
        .end_of_text (end_of_text),
        .mode        (mode),
        .keys        (keys),
        .q_full      (q_full),
        .push        (push),
        .job         (job)
    );

    hc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .job_in (job),
        .pop    (pop),
        .head   (head),
        .full   (q_full),
        .empty  (q_empty)
    );

    hc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .keys       (keys),
        .head       (head),
        .empty      (q_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .letter_out (letter_out),
        .key_bad    (key_bad),
        .pair_last  (pair_last),
        .text_last  (text_last)
    );

endmodule
